FILE: rtl/core/xs64s_pkg.sv
// Shared types, constants and the xorshift round for the xorshift64* random source.
`default_nettype none
package xs64s_pkg;

    // Generator constants
    localparam logic [63:0] MIX_MULT   = 64'h2545_F491_4F6C_DD1D;
    localparam int          SHIFT_A    = 12;
    localparam int          SHIFT_B    = 25;
    localparam int          SHIFT_C    = 27;
    localparam int          FRAC_SHIFT = 40;
    localparam int          FRAC_BITS  = 24;
    localparam int          WARM_ROUNDS = 4;

    // Opcodes of a request
    localparam logic OP_SEED = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    // Datapath step codes
    typedef logic [2:0] t_step;
    localparam t_step STEP_NONE  = 3'd0;
    localparam t_step STEP_MUL0  = 3'd1;
    localparam t_step STEP_MUL1  = 3'd2;
    localparam t_step STEP_MUL2  = 3'd3;
    localparam t_step STEP_MUL3  = 3'd4;
    localparam t_step STEP_SCALE = 3'd5;

    // Controller to datapath
    typedef struct packed {
        logic  load;   // capture the request, seed or advance the state
        logic  round;  // one warm-up xorshift round
        t_step step;   // multiply / scale step
        logic  write;  // load the result register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;    // result register can take a new result
        logic state_zero;  // generator state is all zero (never expected)
    } t_dp_status;

    // One xorshift round
    function automatic logic [63:0] xs_round(input logic [63:0] x);
        logic [63:0] y;
        y = x ^ (x >> SHIFT_A);
        y = y ^ (y << SHIFT_B);
        y = y ^ (y >> SHIFT_C);
        return y;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/xs64s_ctrl.sv
// Controller state machine for the xorshift64* random source.
`default_nettype none
module xs64s_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    input  wire                    i_opcode,
    input  xs64s_pkg::t_dp_status  i_status,
    output logic                   o_in_stall,
    output xs64s_pkg::t_dp_cmd     o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WARM  = 3'd1;
    localparam logic [2:0] S_MUL0  = 3'd2;
    localparam logic [2:0] S_MUL1  = 3'd3;
    localparam logic [2:0] S_MUL2  = 3'd4;
    localparam logic [2:0] S_MUL3  = 3'd5;
    localparam logic [2:0] S_SCALE = 3'd6;
    localparam logic [2:0] S_WRITE = 3'd7;

    localparam logic [1:0] WARM_LAST = 2'(xs64s_pkg::WARM_ROUNDS - 1);

    logic [2:0] r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic       accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_cmd.step = xs64s_pkg::STEP_NONE;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = (i_opcode == xs64s_pkg::OP_SEED) ? S_WARM : S_MUL0;
                end
            end
            S_WARM: begin
                o_cmd.round = 1'b1;
                n_cnt       = r_cnt + 2'd1;
                if (r_cnt == WARM_LAST) begin
                    n_state = S_WRITE;
                end
            end
            S_MUL0: begin
                o_cmd.step = xs64s_pkg::STEP_MUL0;
                n_state    = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.step = xs64s_pkg::STEP_MUL1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.step = xs64s_pkg::STEP_MUL2;
                n_state    = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.step = xs64s_pkg::STEP_MUL3;
                n_state    = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.step = xs64s_pkg::STEP_SCALE;
                n_state    = S_WRITE;
            end
            S_WRITE: begin
                // hold here while the previous result is still stalled
                if (i_status.out_free) begin
                    o_cmd.write = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/xs64s_dpath.sv
// Datapath: generator state, shared 32x32 multiplier, range scaling and result register.
`default_nettype none
module xs64s_dpath (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  xs64s_pkg::t_dp_cmd     i_cmd,
    input  wire                    i_opcode,
    input  wire  [31:0]            i_seed_value,
    input  wire  signed [31:0]     i_range_low,
    input  wire  signed [31:0]     i_range_high,
    input  wire                    i_out_stall,
    output xs64s_pkg::t_dp_status  o_status,
    output logic                   o_out_valid,
    output logic                   o_was_draw,
    output logic [23:0]            o_fraction,
    output logic signed [31:0]     o_scaled_value
);

    localparam logic signed [34:0] SAT_MAX = 35'sh0_7FFF_FFFF;
    localparam logic signed [34:0] SAT_MIN = -35'sh0_8000_0000;

    logic [63:0]        r_gen;
    logic               r_draw;
    logic signed [31:0] r_lo;
    logic signed [32:0] r_span;
    logic [63:0]        r_prod;
    logic [63:0]        r_acc;
    logic signed [57:0] r_sprod;
    logic               r_out_valid;
    logic               r_was_draw;
    logic [23:0]        r_frac;
    logic signed [31:0] r_scaled;

    logic [31:0]        mul_a, mul_b;
    logic [31:0]        seed_nz;
    logic [23:0]        frac;
    logic signed [33:0] quot;
    logic signed [34:0] sum;
    logic signed [31:0] sat;

    assign seed_nz = (i_seed_value == 32'd0) ? 32'd1 : i_seed_value;
    assign frac    = r_acc[63:xs64s_pkg::FRAC_SHIFT];

    // Operand select for the shared multiplier (low 64 bits of state x constant)
    always_comb begin
        case (i_cmd.step)
            xs64s_pkg::STEP_MUL0: begin
                mul_a = r_gen[31:0];
                mul_b = xs64s_pkg::MIX_MULT[31:0];
            end
            xs64s_pkg::STEP_MUL1: begin
                mul_a = r_gen[31:0];
                mul_b = xs64s_pkg::MIX_MULT[63:32];
            end
            default: begin
                mul_a = r_gen[63:32];
                mul_b = xs64s_pkg::MIX_MULT[31:0];
            end
        endcase
    end

    // Generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= 64'd1;
        end else if (i_cmd.load) begin
            if (i_opcode == xs64s_pkg::OP_SEED) begin
                r_gen <= {32'd0, seed_nz};
            end else begin
                r_gen <= xs64s_pkg::xs_round(r_gen);
            end
        end else if (i_cmd.round) begin
            r_gen <= xs64s_pkg::xs_round(r_gen);
        end
    end

    // Request capture and multiply steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_draw <= (i_opcode == xs64s_pkg::OP_DRAW);
            r_lo   <= i_range_low;
            r_span <= 33'(i_range_high) - 33'(i_range_low);
        end
        case (i_cmd.step)
            xs64s_pkg::STEP_MUL0: begin
                r_prod <= 64'(mul_a) * 64'(mul_b);
            end
            xs64s_pkg::STEP_MUL1: begin
                r_acc  <= r_prod;
                r_prod <= 64'(mul_a) * 64'(mul_b);
            end
            xs64s_pkg::STEP_MUL2: begin
                r_acc  <= r_acc + {r_prod[31:0], 32'd0};
                r_prod <= 64'(mul_a) * 64'(mul_b);
            end
            xs64s_pkg::STEP_MUL3: begin
                r_acc <= r_acc + {r_prod[31:0], 32'd0};
            end
            xs64s_pkg::STEP_SCALE: begin
                r_sprod <= 58'(r_span) * 58'($signed({1'b0, frac}));
            end
            default: begin
            end
        endcase
    end

    // Floor divide by 2^24, add the low end, saturate
    always_comb begin
        quot = 34'(r_sprod >>> xs64s_pkg::FRAC_BITS);
        sum  = 35'(r_lo) + 35'(quot);
        if (sum > SAT_MAX) begin
            sat = SAT_MAX[31:0];
        end else if (sum < SAT_MIN) begin
            sat = SAT_MIN[31:0];
        end else begin
            sat = sum[31:0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.write) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_was_draw <= r_draw;
            r_frac     <= r_draw ? frac : 24'd0;
            r_scaled   <= r_draw ? sat : 32'sd0;
        end
    end

    assign o_status.out_free   = !r_out_valid || !i_out_stall;
    assign o_status.state_zero = (r_gen == 64'd0);
    assign o_out_valid         = r_out_valid;
    assign o_was_draw          = r_was_draw;
    assign o_fraction          = r_frac;
    assign o_scaled_value      = r_scaled;

endmodule
`default_nettype wire

FILE: rtl/core/xorshift64_star_random_source.sv
// Top level of the xorshift64* random source: controller plus datapath.
//
// Requests arrive on the input channel (i_in_valid / o_in_stall) and carry
// an opcode: seed loads i_seed_value (zero becomes one) and runs four
// warm-up rounds; draw advances the generator by one round and returns a
// 24-bit fraction and range_low + fraction * (range_high - range_low),
// floored, in signed Q16.16. Each request gives exactly one result on the
// output channel (o_out_valid / i_out_stall); a seed result carries
// was_draw = 0 and zero fields.
// Timing: one request at a time. A seed runs the warm-up rounds and a
// draw the multiply steps before the write: the 64-bit state product goes
// through one shared 32x32 multiplier as three partial products, then a
// 33x25 scaling multiply; the saturating add is combinational. The result
// is loaded into the output register in the write state.
// Stalls: a result waits in the output register while i_out_stall is high;
// the next request is taken meanwhile, and its result waits until the
// register is taken.
// Reset: synchronous, active low; the generator state returns to one and
// no result is pending.
`default_nettype none
module xorshift64_star_random_source (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire                 i_opcode,
    input  wire  [31:0]         i_seed_value,
    input  wire  signed [31:0]  i_range_low,
    input  wire  signed [31:0]  i_range_high,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output logic                o_was_draw,
    output logic [23:0]         o_fraction,
    output logic signed [31:0]  o_scaled_value
);

    xs64s_pkg::t_dp_cmd    cmd;
    xs64s_pkg::t_dp_status status;

    xs64s_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    xs64s_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_opcode       (i_opcode),
        .i_seed_value   (i_seed_value),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .i_out_stall    (i_out_stall),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .o_was_draw     (o_was_draw),
        .o_fraction     (o_fraction),
        .o_scaled_value (o_scaled_value)
    );

    // An accepted request keeps the input side busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after accept");

    // The generator state never reaches zero
    a_state_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !status.state_zero)
        else $error("generator state is zero");

    // Seed results carry zero fields
    a_seed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_was_draw) |-> (o_fraction == 24'd0 && o_scaled_value == 32'sd0))
        else $error("seed result with nonzero fields");

    // A result is written only into a free output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.write |-> (!o_out_valid || !i_out_stall))
        else $error("stalled result overwritten");

endmodule
`default_nettype wire
